// File: design/dec_pkg.sv
// Shared types and constants for the double/extended converter.
`timescale 1ns / 1ps
package dec_pkg;
    localparam int ExtBias = 16383;
    localparam int DblBias = 1023;
    localparam logic [14:0] ExtExpMax = 15'h7FFF;
    localparam logic [10:0] DblExpMax = 11'h7FF;
    localparam logic [63:0] DblInf = 64'h7FF0000000000000;

    typedef enum logic {
        t_MODE_WIDEN  = 1'b0,
        t_MODE_NARROW = 1'b1
    } t_mode;

    typedef struct packed {
        logic        mode;
        logic [63:0] double_in;
        logic [15:0] ext_sign_exp_in;
        logic [63:0] ext_significand_in;
    } t_in_item;

    typedef struct packed {
        logic [15:0] ext_sign_exp_out;
        logic [63:0] ext_significand_out;
        logic [63:0] double_out;
        logic        special_flag;
    } t_out_item;

    // Leading zero count of a 64-bit word, 64 when the word is zero.
    function automatic logic [6:0] lzc64(input logic [63:0] v);
        logic [6:0] n;
        logic       found;
        n = 7'd64;
        found = 1'b0;
        for (int i = 63; i >= 0; i--) begin
            if (!found && v[i]) begin
                n = 7'(63 - i);
                found = 1'b1;
            end
        end
        return n;
    endfunction
endpackage

// File: design/dec_widen.sv
// Binary64 to 80-bit extended conversion, exact.
`timescale 1ns / 1ps
module dec_widen (
    input  logic [63:0] i_double,
    output logic [15:0] o_sign_exp,
    output logic [63:0] o_significand,
    output logic        o_special
);
    import dec_pkg::*;

    logic        neg;
    logic [10:0] e;
    logic [51:0] m;
    logic [6:0]  lz;
    logic [63:0] m64;

    assign neg = i_double[63];
    assign e   = i_double[62:52];
    assign m   = i_double[51:0];
    assign m64 = {12'd0, m};
    assign lz  = lzc64(m64);

    always_comb begin
        o_special = 1'b0;
        o_sign_exp = 16'd0;
        o_significand = 64'd0;
        if (e == DblExpMax) begin
            // NaN loses its sign
            o_special = 1'b1;
            o_sign_exp = {(m == 52'd0) && neg, ExtExpMax};
        end else if (e != 11'd0) begin
            o_sign_exp = {neg, 15'(16'(e) + 16'd15360)};
            o_significand = {1'b1, m, 11'd0};
        end else if (m != 52'd0) begin
            o_sign_exp = {neg, 15'(16'd15372 - 16'(lz))};
            o_significand = m64 << lz;
        end
    end
endmodule

// File: design/dec_narrow.sv
// 80-bit extended to binary64 conversion, round to nearest even.
`timescale 1ns / 1ps
module dec_narrow (
    input  logic [15:0] i_sign_exp,
    input  logic [63:0] i_significand,
    output logic [63:0] o_double,
    output logic        o_special
);
    import dec_pkg::*;

    logic               sgn;
    logic [14:0]        ex;
    logic [6:0]         lz;
    logic [63:0]        n;
    logic signed [17:0] e;
    logic signed [17:0] drop_raw;
    logic [6:0]         drop;
    logic [63:0]        kept;
    logic [63:0]        rem;
    logic [63:0]        half;
    logic [63:0]        mask;
    logic               up;
    logic [63:0]        kept_r;
    logic [10:0]        bexp;

    assign sgn = i_sign_exp[15];
    assign ex  = i_sign_exp[14:0];
    assign lz  = lzc64(i_significand);
    assign n   = i_significand << lz[5:0];
    assign e   = 18'(ex) - 18'(ExtBias) - 18'(lz);
    assign drop_raw = -18'sd1011 - e;
    assign bexp = 11'(e + 18'sd1022);

    always_comb begin
        mask = 64'd0;
        drop = 7'd11;
        if (drop_raw > 18'sd11) drop = (drop_raw > 18'sd65) ? 7'd65 : 7'(drop_raw);
        if (drop >= 7'd64) begin
            kept = 64'd0;
            half = 64'h8000000000000000;
            rem = n;
        end else begin
            kept = n >> drop[5:0];
            half = 64'd1 << (drop[5:0] - 6'd1);
            mask = (64'd1 << drop[5:0]) - 64'd1;
            rem = n & mask;
        end
        up = (rem > half) || ((rem == half) && kept[0]);
        kept_r = kept + {63'd0, up};
        o_special = 1'b0;
        if (ex == ExtExpMax) begin
            o_special = 1'b1;
            o_double = {sgn, 63'd0} | DblInf;
        end else if (i_significand == 64'd0) begin
            o_double = {sgn, 63'd0};
        end else if (e > 18'sd1023) begin
            o_double = {sgn, 63'd0} | DblInf;
        end else if (drop > 7'd64) begin
            o_double = {sgn, 63'd0};
        end else if (e >= -18'sd1022) begin
            o_double = {sgn, 63'd0} | (({bexp, 52'd0}) + kept_r);
        end else begin
            o_double = {sgn, 63'd0} | kept_r;
        end
    end
endmodule

// File: design/double_extended_converter.sv
// Top level of the binary64 / 80-bit extended converter.
`timescale 1ns / 1ps
// Converts one item per cycle, mode 0 widening binary64 to extended and
// mode 1 narrowing extended to binary64 with round to nearest even. An
// accepted item is registered, converted by one pass of combinational
// logic (leading zero count, shift, round), and its result is registered;
// a new item may enter every cycle as long as the output side takes results;
// a stalled result stalls the input once the input register is also full.
module double_extended_converter (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // double_in[63:0], ext_sign_exp_in[79:64], ext_significand_in[143:80]
    input  logic [143:0] s_axis_tdata,
    // mode
    input  logic         s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // ext_sign_exp_out[15:0], ext_significand_out[79:16], double_out[143:80]
    output logic [143:0] m_axis_tdata,
    // special_flag
    output logic         m_axis_tuser
);
    import dec_pkg::*;

    t_in_item  r_in;
    logic      r_in_vld;
    t_out_item r_out;
    logic      r_out_vld;
    t_out_item n_out;
    logic      adv_out;
    logic      adv_in;
    logic [15:0] w_se;
    logic [63:0] w_sig;
    logic        w_fw;
    logic [63:0] w_dbl;
    logic        w_fn;

    assign adv_out = !r_out_vld || m_axis_tready;
    assign adv_in  = !r_in_vld || adv_out;
    assign s_axis_tready = adv_in;

    dec_widen u_widen (
        .i_double(r_in.double_in), .o_sign_exp(w_se),
        .o_significand(w_sig), .o_special(w_fw)
    );
    dec_narrow u_narrow (
        .i_sign_exp(r_in.ext_sign_exp_in), .i_significand(r_in.ext_significand_in),
        .o_double(w_dbl), .o_special(w_fn)
    );

    always_comb begin
        n_out = '0;
        if (r_in.mode == t_MODE_WIDEN) begin
            n_out.ext_sign_exp_out = w_se;
            n_out.ext_significand_out = w_sig;
            n_out.special_flag = w_fw;
        end else begin
            n_out.double_out = w_dbl;
            n_out.special_flag = w_fn;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (adv_in) r_in_vld <= s_axis_tvalid;
            if (adv_out) r_out_vld <= r_in_vld;
        end
        if (adv_in && s_axis_tvalid) begin
            r_in.mode <= s_axis_tuser;
            r_in.double_in <= s_axis_tdata[63:0];
            r_in.ext_sign_exp_in <= s_axis_tdata[79:64];
            r_in.ext_significand_in <= s_axis_tdata[143:80];
        end
        if (adv_out && r_in_vld) r_out <= n_out;
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata = {r_out.double_out, r_out.ext_significand_out,
                           r_out.ext_sign_exp_out};
    assign m_axis_tuser = r_out.special_flag;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");
    a_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_vld && !adv_out |-> !s_axis_tready)
        else $error("input taken while stage full");
    a_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> r_in_vld)
        else $error("accepted item lost");
endmodule

// File: tb/double_extended_converter_tb.sv
// Self-checking testbench for the binary64 / 80-bit extended converter.
`timescale 1ns / 1ps
module double_extended_converter_tb;
    import dec_pkg::*;

    localparam int NumRandom = 800;
    localparam int CycleLimit = 200000;

    typedef struct packed {
        logic [15:0] se;
        logic [63:0] sig;
        logic [63:0] dbl;
        logic        flag;
    } conv_res_t;

    typedef struct {
        t_mode       mode;
        logic [63:0] dbl;
        logic [15:0] se;
        logic [63:0] sig;
        logic        known;
        conv_res_t   res;
    } vec_t;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [143:0] s_axis_tdata;
    logic         s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [143:0] m_axis_tdata;
    logic         m_axis_tuser;

    conv_res_t expected_q[$];
    int        errors;
    int        cycles;
    bit        calm;
    bit        hold_long;
    bit        rand_phase;
    bit        stim_done;

    double_extended_converter u_top (.*);

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic int count_lead(input logic [63:0] v);
        for (int i = 63; i >= 0; i--) if (v[i]) return 63 - i;
        return 64;
    endfunction

    // Widening: exact, -0 and NaN lose their sign, inf/NaN raise the flag.
    function automatic conv_res_t widen_double(input logic [63:0] d);
        conv_res_t r;
        logic [10:0] e;
        logic [51:0] m;
        int lz;
        r = '0;
        e = d[62:52];
        m = d[51:0];
        if (e == 11'h7FF) begin
            r.se = {(m == 0) && d[63], 15'h7FFF};
            r.flag = 1'b1;
        end else if (e == 0 && m == 0) begin
            r.se = '0;
        end else if (e != 0) begin
            r.se = {d[63], 15'(e + 15360)};
            r.sig = {1'b1, m, 11'b0};
        end else begin
            lz = count_lead({12'b0, m});
            r.se = {d[63], 15'(15372 - lz)};
            r.sig = {12'b0, m} << lz;
        end
        return r;
    endfunction

    // Narrowing: one round to nearest even, overflow to inf, underflow down.
    function automatic conv_res_t narrow_ext(input logic [15:0] se, input logic [63:0] sig);
        conv_res_t r;
        logic [63:0] sgn, n, kept, rem, half;
        int lz, e, drop;
        r = '0;
        sgn = {se[15], 63'b0};
        if (se[14:0] == 15'h7FFF) begin
            r.dbl = sgn | DblInf;
            r.flag = 1'b1;
            return r;
        end
        if (sig == 0) begin
            r.dbl = sgn;
            return r;
        end
        lz = count_lead(sig);
        n = sig << lz;
        e = int'(se[14:0]) - ExtBias - lz;
        if (e > DblBias) begin
            r.dbl = sgn | DblInf;
            return r;
        end
        drop = -1011 - e;
        if (drop < 11) drop = 11;
        if (drop > 64) begin
            r.dbl = sgn;
            return r;
        end
        if (drop == 64) begin
            kept = 0;
            half = 64'h8000000000000000;
            rem = n;
        end else begin
            kept = n >> drop;
            half = 64'd1 << (drop - 1);
            rem = n & ((64'd1 << drop) - 1);
        end
        if (rem > half || (rem == half && kept[0])) kept++;
        if (e >= -1022) r.dbl = sgn | ((64'(e + 1022) << 52) + kept);
        else r.dbl = sgn | kept;
        return r;
    endfunction

    function automatic conv_res_t convert(input t_mode md, input logic [63:0] d,
                                          input logic [15:0] se, input logic [63:0] sig);
        if (md == t_MODE_WIDEN) return widen_double(d);
        return narrow_ext(se, sig);
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    task automatic send_item(input t_mode md, input logic [63:0] d, input logic [15:0] se,
                             input logic [63:0] sig, input bit known, input conv_res_t res);
        conv_res_t pred;
        int gap;
        if (!calm && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 10);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        pred = convert(md, d, se, sig);
        if (known && pred != res) begin
            $display("%0t predictor row mismatch exp %h act %h", $time, res, pred);
            errors++;
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= md;
        s_axis_tdata <= {sig, se, d};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        expected_q.push_back(pred);
    endtask

    // Random double with biased exponent classes.
    function automatic logic [63:0] rand_double();
        logic [63:0] d;
        d = rand64();
        case ($urandom_range(0, 5))
            0: d[62:52] = 11'h000;
            1: d[62:52] = 11'h7FF;
            2: d[51:0] = $urandom_range(0, 1) ? 52'd0 : 52'(1) << $urandom_range(0, 51);
            default: ;
        endcase
        return d;
    endfunction

    task automatic send_random_narrow();
        logic [15:0] se;
        logic [63:0] sig;
        se = 16'($urandom());
        sig = rand64();
        case ($urandom_range(0, 7))
            0: se[14:0] = 15'(ExtBias - 1022 - $urandom_range(0, 70));
            1: se[14:0] = 15'(ExtBias + 1023 + $urandom_range(0, 2));
            2: se[14:0] = $urandom_range(0, 1) ? 15'h7FFF : 15'h0;
            3: sig = sig >> $urandom_range(1, 64);
            4: sig[10:0] = $urandom_range(0, 1) ? 11'h400 : 11'h3FF;
            default: se[14:0] = 15'(ExtBias - 1100 + $urandom_range(0, 2200));
        endcase
        send_item(t_MODE_NARROW, rand64(), se, sig, 1'b0, '0);
    endtask

    vec_t table_rows[$];

    task automatic add_row(input t_mode md, input logic [63:0] d, input logic [15:0] se,
                           input logic [63:0] sig, input bit known, input conv_res_t res);
        vec_t v;
        v.mode = md; v.dbl = d; v.se = se; v.sig = sig; v.known = known; v.res = res;
        table_rows.push_back(v);
    endtask

    initial begin
        errors = 0;
        calm = 0;
        rand_phase = 0;
        stim_done = 0;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // widening: zeros, infinities, NaN, extremes
        add_row(t_MODE_WIDEN, 64'h0, 0, 0, 1, '0);
        add_row(t_MODE_WIDEN, 64'h8000000000000000, 0, 0, 1, '0);
        add_row(t_MODE_WIDEN, 64'h7FF0000000000000, 0, 0, 1, '{16'h7FFF, 0, 0, 1});
        add_row(t_MODE_WIDEN, 64'hFFF0000000000000, 0, 0, 1, '{16'hFFFF, 0, 0, 1});
        add_row(t_MODE_WIDEN, 64'hFFF8000000000001, 0, 0, 1, '{16'h7FFF, 0, 0, 1});
        add_row(t_MODE_WIDEN, 64'h3FF0000000000000, 0, 0, 1,
                '{16'h3FFF, 64'h8000000000000000, 0, 0});
        add_row(t_MODE_WIDEN, 64'h0000000000000001, 0, 0, 0, '0);
        add_row(t_MODE_WIDEN, 64'h800FFFFFFFFFFFFF, 0, 0, 0, '0);
        add_row(t_MODE_WIDEN, 64'h7FEFFFFFFFFFFFFF, 0, 0, 0, '0);
        add_row(t_MODE_WIDEN, 64'hFFFFFFFFFFFFFFFF, 0, 0, 1, '{16'h7FFF, 0, 0, 1});
        // narrowing: zeros, infinity exponent, overflow, ties, subnormals
        add_row(t_MODE_NARROW, 0, 16'h8000, 64'h0, 1, '{0, 0, 64'h8000000000000000, 0});
        add_row(t_MODE_NARROW, 0, 16'h0000, 64'h0, 1, '0);
        add_row(t_MODE_NARROW, 0, 16'hFFFF, 64'h1234, 1, '{0, 0, 64'hFFF0000000000000, 1});
        add_row(t_MODE_NARROW, 0, 16'h7FFF, 64'h0, 1, '{0, 0, 64'h7FF0000000000000, 1});
        add_row(t_MODE_NARROW, 0, 16'h3FFF, 64'h8000000000000000, 1,
                '{0, 0, 64'h3FF0000000000000, 0});
        add_row(t_MODE_NARROW, 0, 16'h7FFE, 64'hFFFFFFFFFFFFFFFF, 1,
                '{0, 0, 64'h7FF0000000000000, 0});
        add_row(t_MODE_NARROW, 0, 16'h43FE, 64'hFFFFFFFFFFFFFFFF, 0, '0);
        add_row(t_MODE_NARROW, 0, 16'h3FFF, 64'h8000000000000400, 0, '0);
        add_row(t_MODE_NARROW, 0, 16'h3FFF, 64'h8000000000000C00, 0, '0);
        add_row(t_MODE_NARROW, 0, 16'h3C00, 64'hFFFFFFFFFFFFFFFF, 0, '0);
        add_row(t_MODE_NARROW, 0, 16'h3BCC, 64'h8000000000000000, 0, '0);
        add_row(t_MODE_NARROW, 0, 16'h0000, 64'hFFFFFFFFFFFFFFFF, 1, '0);
        add_row(t_MODE_NARROW, 0, 16'h3FFF, 64'h0000000000000001, 0, '0);
        foreach (table_rows[i])
            send_item(table_rows[i].mode, table_rows[i].dbl, table_rows[i].se,
                      table_rows[i].sig, table_rows[i].known, table_rows[i].res);

        // pause until the pipeline drains
        s_axis_tvalid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);

        rand_phase = 1;
        for (int k = 0; k < NumRandom; k++) begin
            if (k == NumRandom * 3 / 4) calm = 1;
            if ($urandom_range(0, 1)) send_item(t_MODE_WIDEN, rand_double(),
                                                16'($urandom()), rand64(), 1'b0, '0);
            else send_random_narrow();
        end
        s_axis_tvalid <= 1'b0;
        stim_done = 1;
    end

    // Receiver: random stalls, one long hold-off early in the random part.
    initial begin
        m_axis_tready = 1'b0;
        hold_long = 0;
        @(posedge i_rst_n);
        forever begin
            if (!hold_long && rand_phase) begin
                hold_long = 1;
                m_axis_tready <= 1'b0;
                repeat (60) @(posedge i_clk);
            end else if (!calm && $urandom_range(0, 3) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
        end
    end

    // Compare each accepted result with the oldest expectation.
    always @(posedge i_clk) begin
        conv_res_t got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = {m_axis_tdata[15:0], m_axis_tdata[79:16], m_axis_tdata[143:80],
                   m_axis_tuser};
            if (expected_q.size() == 0) begin
                $display("%0t unexpected item act %h", $time, got);
                errors++;
            end else begin
                want = expected_q.pop_front();
                if (got.se !== want.se)
                    $display("%0t sign_exp exp %h act %h", $time, want.se, got.se);
                if (got.sig !== want.sig)
                    $display("%0t significand exp %h act %h", $time, want.sig, got.sig);
                if (got.dbl !== want.dbl)
                    $display("%0t double exp %h act %h", $time, want.dbl, got.dbl);
                if (got.flag !== want.flag)
                    $display("%0t flag exp %b act %b", $time, want.flag, got.flag);
                if (got !== want) errors++;
            end
        end
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > CycleLimit) begin
                $display("double_extended_converter_tb NOT OK");
                $finish;
            end
            if (stim_done && expected_q.size() == 0) begin
                repeat (10) @(posedge i_clk);
                if (errors == 0 && expected_q.size() == 0)
                    $display("double_extended_converter_tb OK");
                else
                    $display("double_extended_converter_tb NOT OK");
                $finish;
            end
        end
    end
endmodule
